@@ rtl/acpw_pkg.sv @@
`timescale 1ns / 1ps
package acpw_pkg;

    localparam int WORD_BYTES = 32;
    localparam int COUNT_BITS = 16;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic        first_word;
        logic [63:0] word_0;
        logic [63:0] word_1;
        logic [63:0] word_2;
        logic [63:0] word_3;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  capture_kind;
        logic [1:0]  side;
        logic [5:0]  text_bytes;
        logic [15:0] short_value;
    } out_word_t;

    typedef enum logic [5:0] {
        F_BODY_OFF, F_BENEF, F_SELLER, F_ID, F_URI_OFF, F_CRE_OFF, F_ROY_OFF,
        F_SIGS_OFF, F_URI_LEN, F_URI_DATA, F_CRE_QTY, F_CRE_ADDR, F_CRE_VAL,
        F_ROY_QTY, F_ROY_ADDR, F_ROY_VAL, F_SIGS_QTY, F_SIG_OFF, F_SIG_LEN,
        F_SIG_DATA, F_DONE,
        F_MAKER, F_MAKE_OFF, F_TAKER, F_TAKE_OFF, F_SALT, F_START, F_END,
        F_DTYPE, F_DOFF, F_MAKE_ASSET, F_TAKE_ASSET, F_ODATA_LEN, F_ODATA,
        F_OSIG_LEN, F_OSIG,
        F_LEFT_OFF, F_LSIG_OFF, F_RIGHT_OFF, F_RSIG_OFF,
        F_TO, F_APPROVED,
        F_NAME_OFF, F_SYM_OFF, F_BURI_OFF, F_CURI_OFF, F_OPS_OFF, F_TSALT,
        F_PROXY, F_LAZY, F_NAME_LEN, F_NAME, F_SYM_LEN, F_SYM, F_BURI_LEN,
        F_BURI, F_CURI_LEN, F_CURI, F_OPS_QTY, F_OP_ADDR, F_OP_VAL
    } field_t;

    localparam logic [2:0] KIND_MINT     = 3'd0;
    localparam logic [2:0] KIND_CANCEL   = 3'd1;
    localparam logic [2:0] KIND_MATCH    = 3'd2;
    localparam logic [2:0] KIND_TRANSFER = 3'd3;
    localparam logic [2:0] KIND_APPROVE  = 3'd4;
    localparam logic [2:0] KIND_CREATE   = 3'd5;
    localparam logic [2:0] KIND_INIT     = 3'd6;

    localparam logic [3:0] CAP_NONE     = 4'd0;
    localparam logic [3:0] CAP_MAKER    = 4'd1;
    localparam logic [3:0] CAP_TAKER    = 4'd2;
    localparam logic [3:0] CAP_BENEF    = 4'd3;
    localparam logic [3:0] CAP_SELLER   = 4'd4;
    localparam logic [3:0] CAP_ID       = 4'd5;
    localparam logic [3:0] CAP_CREATOR  = 4'd6;
    localparam logic [3:0] CAP_ROYALTY  = 4'd7;
    localparam logic [3:0] CAP_NAME     = 4'd8;
    localparam logic [3:0] CAP_SYMBOL   = 4'd9;
    localparam logic [3:0] CAP_PROXY    = 4'd10;
    localparam logic [3:0] CAP_LAZY     = 4'd11;
    localparam logic [3:0] CAP_OPERATOR = 4'd12;
    localparam logic [3:0] CAP_APPROVAL = 4'd13;
    localparam logic [3:0] CAP_TO       = 4'd14;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;
    localparam logic [1:0] SIDE_PAST  = 2'd3;

    typedef struct packed {
        field_t      field_step;
        logic [2:0]  asset_step;
        count_t      skip_count;
        count_t      skip_start;
        count_t      text_length;
        count_t      list_count;
        count_t      signature_words;
        count_t      signature_count;
        logic [1:0]  side_of_order;
    } walk_state_t;

    function automatic field_t first_field(input logic [2:0] kind);
        field_t f;
        case (kind)
            KIND_MINT, KIND_CANCEL, KIND_TRANSFER: f = F_BODY_OFF;
            KIND_MATCH:                            f = F_LEFT_OFF;
            KIND_APPROVE:                          f = F_TO;
            KIND_CREATE, KIND_INIT:                f = F_NAME_OFF;
            default:                               f = F_DONE;
        endcase
        return f;
    endfunction

    function automatic walk_state_t restart_state(input logic [2:0] kind);
        walk_state_t s;
        s = '0;
        s.field_step = first_field(kind);
        return s;
    endfunction

endpackage

@@ rtl/abi_call_parameter_walker_top.sv @@
`timescale 1ns / 1ps
// walks the 32-byte argument words of one contract call, one word per cycle: each accepted
// word is classified by a single combinational step against the walk state, and its result
// word is loaded into the output register at the accepting edge, so it is offered in the next
// cycle; a new word is taken every cycle while the output register is empty or being
// drained. first_word restarts the walk, and a call_kind write (register 0) restarts it for
// the new layout
module abi_call_parameter_walker_top
    import acpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data
);

    logic [2:0]  call_kind;
    logic        kind_write;
    walk_state_t state_reg;
    walk_state_t state_next;
    out_word_t   res;
    out_word_t   out_reg;
    logic        out_valid_reg;
    logic        take;

    acpw_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .call_kind  (call_kind),
        .kind_write (kind_write)
    );

    acpw_step u_step (
        .call_kind (call_kind),
        .cur       (state_reg),
        .word      (in_data),
        .nxt       (state_next),
        .res       (res)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= restart_state(KIND_MINT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (kind_write)
            begin
                state_reg <= restart_state(pwdata[2:0]);
            end
            else if (take)
            begin
                state_reg <= state_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= res;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    a_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_bytes != 6'd0 |->
        out_data.capture_kind == CAP_NAME || out_data.capture_kind == CAP_SYMBOL)
        else $error("text bytes on non-text capture");

endmodule

@@ rtl/acpw_cfg.sv @@
`timescale 1ns / 1ps
module acpw_cfg
    import acpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  call_kind,
    output logic        kind_write
);

    logic [2:0] call_kind_reg;

    assign pready     = 1'b1;
    assign kind_write = psel && penable && pwrite && (paddr == 1'b0);
    assign call_kind  = call_kind_reg;
    assign prdata     = (paddr == 1'b0) ? {29'd0, call_kind_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_kind_reg <= KIND_MINT;
        end
        else if (kind_write)
        begin
            call_kind_reg <= pwdata[2:0];
        end
    end

endmodule

@@ rtl/acpw_step.sv @@
`timescale 1ns / 1ps
module acpw_step
    import acpw_pkg::*;
(
    input  logic [2:0]  call_kind,
    input  walk_state_t cur,
    input  in_word_t    word,
    output walk_state_t nxt,
    output out_word_t   res
);

    walk_state_t s;
    count_t      w_count;
    logic [15:0] w_low16;
    count_t      n_words;
    logic        done;

    assign w_count = word.word_3[COUNT_BITS-1:0];
    assign w_low16 = word.word_3[15:0];
    assign n_words = count_t'(({1'b0, w_count} + (COUNT_BITS+1)'(WORD_BYTES - 1))
                     >> $clog2(WORD_BYTES));

    always_comb
    begin
        s    = word.first_word ? restart_state(call_kind) : cur;
        res  = '0;
        res.side = s.side_of_order;
        done = 1'b0;
        case (call_kind)
            KIND_MINT, KIND_TRANSFER:
            begin
                case (s.field_step)
                    F_BODY_OFF: s.field_step = F_BENEF;
                    F_BENEF:
                    begin
                        res.capture_kind = CAP_BENEF;
                        s.field_step = (call_kind == KIND_TRANSFER) ? F_SELLER : F_ID;
                    end
                    F_SELLER:
                    begin
                        if (call_kind != KIND_TRANSFER) res.status = 1'b1;
                        else
                        begin
                            res.capture_kind = CAP_SELLER;
                            s.field_step = F_ID;
                        end
                    end
                    F_ID:
                    begin
                        res.capture_kind = CAP_ID;
                        s.field_step = F_URI_OFF;
                    end
                    F_URI_OFF:  s.field_step = F_CRE_OFF;
                    F_CRE_OFF:  s.field_step = F_ROY_OFF;
                    F_ROY_OFF:  s.field_step = F_SIGS_OFF;
                    F_SIGS_OFF: s.field_step = F_URI_LEN;
                    F_URI_LEN:
                    begin
                        if (n_words == '0) s.field_step = F_CRE_QTY;
                        else
                        begin
                            s.skip_count = n_words;
                            s.field_step = F_URI_DATA;
                        end
                    end
                    F_URI_DATA:
                    begin
                        if (s.skip_count <= count_t'(1))
                        begin
                            s.skip_count = '0;
                            s.field_step = F_CRE_QTY;
                        end
                        else s.skip_count = s.skip_count - count_t'(1);
                    end
                    F_CRE_QTY:
                    begin
                        s.list_count = w_count;
                        s.field_step = (w_count == '0) ? F_ROY_QTY : F_CRE_ADDR;
                    end
                    F_CRE_ADDR:
                    begin
                        if (s.list_count == count_t'(1)) res.capture_kind = CAP_CREATOR;
                        s.field_step = F_CRE_VAL;
                    end
                    F_CRE_VAL:
                    begin
                        if (s.list_count <= count_t'(1))
                        begin
                            s.list_count = '0;
                            s.field_step = F_ROY_QTY;
                        end
                        else
                        begin
                            s.list_count = s.list_count - count_t'(1);
                            s.field_step = F_CRE_ADDR;
                        end
                    end
                    F_ROY_QTY:
                    begin
                        s.list_count = w_count;
                        s.field_step = (w_count == '0) ? F_SIGS_QTY : F_ROY_ADDR;
                    end
                    F_ROY_ADDR: s.field_step = F_ROY_VAL;
                    F_ROY_VAL:
                    begin
                        if (s.list_count == count_t'(1))
                        begin
                            res.capture_kind = CAP_ROYALTY;
                            res.short_value  = w_low16;
                        end
                        if (s.list_count <= count_t'(1))
                        begin
                            s.list_count = '0;
                            s.field_step = F_SIGS_QTY;
                        end
                        else
                        begin
                            s.list_count = s.list_count - count_t'(1);
                            s.field_step = F_ROY_ADDR;
                        end
                    end
                    F_SIGS_QTY:
                    begin
                        s.signature_count = w_count;
                        s.skip_count      = w_count;
                        s.field_step = (w_count == '0) ? F_DONE : F_SIG_OFF;
                    end
                    F_SIG_OFF:
                    begin
                        if (s.skip_count <= count_t'(1))
                        begin
                            s.skip_count = '0;
                            s.field_step = F_SIG_LEN;
                        end
                        else s.skip_count = s.skip_count - count_t'(1);
                    end
                    F_SIG_LEN, F_SIG_DATA:
                    begin
                        if (s.field_step == F_SIG_LEN)
                        begin
                            if (n_words == '0) done = 1'b1;
                            else
                            begin
                                s.signature_words = n_words;
                                s.field_step = F_SIG_DATA;
                            end
                        end
                        else if (s.signature_words <= count_t'(1))
                        begin
                            s.signature_words = '0;
                            done = 1'b1;
                        end
                        else s.signature_words = s.signature_words - count_t'(1);
                        if (done)
                        begin
                            if (s.signature_count <= count_t'(1))
                            begin
                                s.signature_count = '0;
                                s.field_step = F_DONE;
                            end
                            else
                            begin
                                s.signature_count = s.signature_count - count_t'(1);
                                s.field_step = F_SIG_LEN;
                            end
                        end
                    end
                    default: res.status = 1'b1;
                endcase
            end
            KIND_CANCEL, KIND_MATCH:
            begin
                if (call_kind == KIND_CANCEL && s.field_step == F_BODY_OFF)
                    s.field_step = F_MAKER;
                else if (call_kind == KIND_MATCH && s.side_of_order == SIDE_NONE)
                begin
                    case (s.field_step)
                        F_LEFT_OFF:  s.field_step = F_LSIG_OFF;
                        F_LSIG_OFF:  s.field_step = F_RIGHT_OFF;
                        F_RIGHT_OFF: s.field_step = F_RSIG_OFF;
                        F_RSIG_OFF:
                        begin
                            s.side_of_order = SIDE_LEFT;
                            s.field_step = F_MAKER;
                        end
                        default: res.status = 1'b1;
                    endcase
                end
                else if (call_kind == KIND_MATCH && s.side_of_order == SIDE_PAST)
                    res.status = 1'b1;
                else
                begin
                    case (s.field_step)
                        F_MAKER:
                        begin
                            res.capture_kind = CAP_MAKER;
                            s.field_step = F_MAKE_OFF;
                        end
                        F_MAKE_OFF: s.field_step = F_TAKER;
                        F_TAKER:
                        begin
                            res.capture_kind = CAP_TAKER;
                            s.field_step = F_TAKE_OFF;
                        end
                        F_TAKE_OFF: s.field_step = F_SALT;
                        F_SALT:     s.field_step = F_START;
                        F_START:    s.field_step = F_END;
                        F_END:      s.field_step = F_DTYPE;
                        F_DTYPE:    s.field_step = F_DOFF;
                        F_DOFF:
                        begin
                            s.field_step = F_MAKE_ASSET;
                            s.asset_step = 3'd0;
                        end
                        F_MAKE_ASSET, F_TAKE_ASSET:
                        begin
                            case (s.asset_step)
                                3'd0, 3'd1, 3'd2, 3'd3:
                                    s.asset_step = s.asset_step + 3'd1;
                                3'd4:
                                begin
                                    if (n_words == '0) done = 1'b1;
                                    else
                                    begin
                                        s.skip_count = n_words;
                                        s.asset_step = 3'd5;
                                    end
                                end
                                3'd5:
                                begin
                                    if (s.skip_count <= count_t'(1))
                                    begin
                                        s.skip_count = '0;
                                        done = 1'b1;
                                    end
                                    else s.skip_count = s.skip_count - count_t'(1);
                                end
                                default: res.status = 1'b1;
                            endcase
                            if (done)
                            begin
                                s.field_step = (s.field_step == F_MAKE_ASSET) ?
                                               F_TAKE_ASSET : F_ODATA_LEN;
                                s.asset_step = 3'd0;
                            end
                        end
                        F_ODATA_LEN:
                        begin
                            if (n_words == '0) s.field_step = F_OSIG_LEN;
                            else
                            begin
                                s.skip_count = n_words;
                                s.field_step = F_ODATA;
                            end
                        end
                        F_ODATA:
                        begin
                            if (s.skip_count <= count_t'(1))
                            begin
                                s.skip_count = '0;
                                s.field_step = F_OSIG_LEN;
                            end
                            else s.skip_count = s.skip_count - count_t'(1);
                        end
                        F_OSIG_LEN:
                        begin
                            if (n_words == '0) done = 1'b1;
                            else
                            begin
                                s.skip_count = n_words;
                                s.field_step = F_OSIG;
                            end
                        end
                        F_OSIG:
                        begin
                            if (s.skip_count <= count_t'(1))
                            begin
                                s.skip_count = '0;
                                done = 1'b1;
                            end
                            else s.skip_count = s.skip_count - count_t'(1);
                        end
                        default: res.status = 1'b1;
                    endcase
                    if (done && (s.field_step == F_OSIG_LEN || s.field_step == F_OSIG))
                    begin
                        s.field_step = F_MAKER;
                        s.side_of_order = (call_kind == KIND_CANCEL) ? SIDE_PAST :
                            ((s.side_of_order == SIDE_LEFT) ? SIDE_RIGHT : SIDE_PAST);
                    end
                end
            end
            KIND_APPROVE:
            begin
                case (s.field_step)
                    F_TO:
                    begin
                        res.capture_kind = CAP_TO;
                        s.field_step = F_APPROVED;
                    end
                    F_APPROVED:
                    begin
                        res.capture_kind = CAP_APPROVAL;
                        res.short_value  = w_low16;
                        s.field_step = F_DONE;
                    end
                    default: res.status = 1'b1;
                endcase
            end
            KIND_CREATE, KIND_INIT:
            begin
                case (s.field_step)
                    F_NAME_OFF: s.field_step = F_SYM_OFF;
                    F_SYM_OFF:  s.field_step = F_BURI_OFF;
                    F_BURI_OFF: s.field_step = F_CURI_OFF;
                    F_CURI_OFF:
                        s.field_step = (call_kind == KIND_INIT) ? F_PROXY : F_OPS_OFF;
                    F_OPS_OFF:
                        if (call_kind == KIND_INIT) res.status = 1'b1;
                        else s.field_step = F_TSALT;
                    F_TSALT:
                        if (call_kind == KIND_INIT) res.status = 1'b1;
                        else s.field_step = F_NAME_LEN;
                    F_PROXY:
                        if (call_kind != KIND_INIT) res.status = 1'b1;
                        else
                        begin
                            res.capture_kind = CAP_PROXY;
                            s.field_step = F_LAZY;
                        end
                    F_LAZY:
                        if (call_kind != KIND_INIT) res.status = 1'b1;
                        else
                        begin
                            res.capture_kind = CAP_LAZY;
                            s.field_step = F_NAME_LEN;
                        end
                    F_NAME_LEN, F_SYM_LEN:
                    begin
                        s.text_length = w_count;
                        s.skip_start  = n_words;
                        if (n_words == '0)
                            s.field_step = (s.field_step == F_NAME_LEN) ? F_SYM_LEN : F_BURI_LEN;
                        else
                        begin
                            s.skip_count = n_words;
                            s.field_step = (s.field_step == F_NAME_LEN) ? F_NAME : F_SYM;
                        end
                    end
                    F_NAME, F_SYM:
                    begin
                        if (s.skip_count == s.skip_start)
                        begin
                            res.capture_kind = (s.field_step == F_NAME) ? CAP_NAME : CAP_SYMBOL;
                            res.text_bytes = (s.text_length < count_t'(WORD_BYTES)) ?
                                6'(s.text_length) : 6'(WORD_BYTES);
                            res.short_value = 16'(s.text_length);
                        end
                        if (s.skip_count <= count_t'(1))
                        begin
                            s.skip_count = '0;
                            s.field_step = (s.field_step == F_NAME) ? F_SYM_LEN : F_BURI_LEN;
                        end
                        else s.skip_count = s.skip_count - count_t'(1);
                    end
                    F_BURI_LEN, F_CURI_LEN:
                    begin
                        if (n_words == '0)
                            s.field_step = (s.field_step == F_BURI_LEN) ? F_CURI_LEN :
                                ((call_kind == KIND_INIT) ? F_DONE : F_OPS_QTY);
                        else
                        begin
                            s.skip_count = n_words;
                            s.field_step = (s.field_step == F_BURI_LEN) ? F_BURI : F_CURI;
                        end
                    end
                    F_BURI, F_CURI:
                    begin
                        if (s.skip_count <= count_t'(1))
                        begin
                            s.skip_count = '0;
                            s.field_step = (s.field_step == F_BURI) ? F_CURI_LEN :
                                ((call_kind == KIND_INIT) ? F_DONE : F_OPS_QTY);
                        end
                        else s.skip_count = s.skip_count - count_t'(1);
                    end
                    F_OPS_QTY:
                        if (call_kind == KIND_INIT) res.status = 1'b1;
                        else
                        begin
                            s.skip_count = w_count;
                            s.field_step = (w_count == '0) ? F_DONE : F_OP_ADDR;
                        end
                    F_OP_ADDR:
                        if (call_kind == KIND_INIT) res.status = 1'b1;
                        else
                        begin
                            if (s.skip_count == count_t'(1)) res.capture_kind = CAP_OPERATOR;
                            s.field_step = F_OP_VAL;
                        end
                    F_OP_VAL:
                        if (call_kind == KIND_INIT) res.status = 1'b1;
                        else if (s.skip_count <= count_t'(1))
                        begin
                            s.skip_count = '0;
                            s.field_step = F_DONE;
                        end
                        else
                        begin
                            s.skip_count = s.skip_count - count_t'(1);
                            s.field_step = F_OP_ADDR;
                        end
                    default: res.status = 1'b1;
                endcase
            end
            default: res.status = 1'b1;
        endcase
        nxt = s;
    end

endmodule

@@ test/abi_call_parameter_walker_top_test.sv @@
`timescale 1ns / 1ps
module abi_call_parameter_walker_top_test;
    import acpw_pkg::*;

    localparam logic [2:0] KIND_UNSUP = 3'd7;

    class walk_scoreboard;
        logic [2:0]  kind;
        field_t      fs;
        logic [2:0]  ast;
        int unsigned skc, sks, tlen, lst, sigw, sigc;
        logic [1:0]  side;
        logic        st;
        logic [3:0]  cap;
        int unsigned txt;
        logic [15:0] shv;
        int unsigned wc;
        out_word_t   expected_words[$];
        int          errs;

        function new();
            kind = KIND_MINT;
            errs = 0;
            restart();
        endfunction

        function void restart();
            case (kind)
                KIND_MINT, KIND_CANCEL, KIND_TRANSFER: fs = F_BODY_OFF;
                KIND_MATCH:                            fs = F_LEFT_OFF;
                KIND_APPROVE:                          fs = F_TO;
                KIND_CREATE, KIND_INIT:                fs = F_NAME_OFF;
                default:                               fs = F_DONE;
            endcase
            ast = 0;
            skc = 0; sks = 0; tlen = 0; lst = 0; sigw = 0; sigc = 0;
            side = SIDE_NONE;
        endfunction

        function void set_kind(logic [2:0] k);
            kind = k;
            restart();
        endfunction

        function int unsigned words_of(int unsigned len);
            return (len + WORD_BYTES - 1) / WORD_BYTES;
        endfunction

        function bit tick(inout int unsigned c);
            if (c <= 1)
            begin
                c = 0;
                return 1;
            end
            c = c - 1;
            return 0;
        endfunction

        function bit walk_asset();
            int unsigned n;
            case (ast)
                3'd0, 3'd1, 3'd2, 3'd3:
                begin
                    ast = ast + 3'd1;
                    return 0;
                end
                3'd4:
                begin
                    n = words_of(wc);
                    if (n == 0)
                        return 1;
                    skc = n;
                    ast = 3'd5;
                    return 0;
                end
                3'd5: return tick(skc);
                default:
                begin
                    st = 1'b1;
                    return 0;
                end
            endcase
        endfunction

        function void end_order(logic [1:0] nside);
            fs = F_MAKER;
            side = nside;
        endfunction

        function void walk_order(logic [1:0] nside);
            int unsigned n;
            case (fs)
                F_MAKER:    begin cap = CAP_MAKER; fs = F_MAKE_OFF; end
                F_MAKE_OFF: fs = F_TAKER;
                F_TAKER:    begin cap = CAP_TAKER; fs = F_TAKE_OFF; end
                F_TAKE_OFF: fs = F_SALT;
                F_SALT:     fs = F_START;
                F_START:    fs = F_END;
                F_END:      fs = F_DTYPE;
                F_DTYPE:    fs = F_DOFF;
                F_DOFF:     begin fs = F_MAKE_ASSET; ast = 3'd0; end
                F_MAKE_ASSET:
                    if (walk_asset())
                    begin
                        fs = F_TAKE_ASSET;
                        ast = 3'd0;
                    end
                F_TAKE_ASSET:
                    if (walk_asset())
                    begin
                        fs = F_ODATA_LEN;
                        ast = 3'd0;
                    end
                F_ODATA_LEN:
                begin
                    n = words_of(wc);
                    if (n == 0)
                        fs = F_OSIG_LEN;
                    else
                    begin
                        skc = n;
                        fs = F_ODATA;
                    end
                end
                F_ODATA:
                    if (tick(skc))
                        fs = F_OSIG_LEN;
                F_OSIG_LEN:
                begin
                    n = words_of(wc);
                    if (n == 0)
                        end_order(nside);
                    else
                    begin
                        skc = n;
                        fs = F_OSIG;
                    end
                end
                F_OSIG:
                    if (tick(skc))
                        end_order(nside);
                default: st = 1'b1;
            endcase
        endfunction

        function void sig_done();
            fs = tick(sigc) ? F_DONE : F_SIG_LEN;
        endfunction

        function void walk_mint(bit ws);
            int unsigned n;
            case (fs)
                F_BODY_OFF: fs = F_BENEF;
                F_BENEF:    begin cap = CAP_BENEF; fs = ws ? F_SELLER : F_ID; end
                F_SELLER:
                    if (!ws)
                        st = 1'b1;
                    else
                    begin
                        cap = CAP_SELLER;
                        fs = F_ID;
                    end
                F_ID:       begin cap = CAP_ID; fs = F_URI_OFF; end
                F_URI_OFF:  fs = F_CRE_OFF;
                F_CRE_OFF:  fs = F_ROY_OFF;
                F_ROY_OFF:  fs = F_SIGS_OFF;
                F_SIGS_OFF: fs = F_URI_LEN;
                F_URI_LEN:
                begin
                    n = words_of(wc);
                    if (n == 0)
                        fs = F_CRE_QTY;
                    else
                    begin
                        skc = n;
                        fs = F_URI_DATA;
                    end
                end
                F_URI_DATA:
                    if (tick(skc))
                        fs = F_CRE_QTY;
                F_CRE_QTY:
                begin
                    lst = wc;
                    fs = (lst == 0) ? F_ROY_QTY : F_CRE_ADDR;
                end
                F_CRE_ADDR:
                begin
                    if (lst == 1)
                        cap = CAP_CREATOR;
                    fs = F_CRE_VAL;
                end
                F_CRE_VAL:  fs = tick(lst) ? F_ROY_QTY : F_CRE_ADDR;
                F_ROY_QTY:
                begin
                    lst = wc;
                    fs = (lst == 0) ? F_SIGS_QTY : F_ROY_ADDR;
                end
                F_ROY_ADDR: fs = F_ROY_VAL;
                F_ROY_VAL:
                begin
                    if (lst == 1)
                    begin
                        cap = CAP_ROYALTY;
                        shv = wc[15:0];
                    end
                    fs = tick(lst) ? F_SIGS_QTY : F_ROY_ADDR;
                end
                F_SIGS_QTY:
                begin
                    sigc = wc;
                    skc = wc;
                    fs = (wc == 0) ? F_DONE : F_SIG_OFF;
                end
                F_SIG_OFF:
                    if (tick(skc))
                        fs = F_SIG_LEN;
                F_SIG_LEN:
                begin
                    n = words_of(wc);
                    if (n == 0)
                        sig_done();
                    else
                    begin
                        sigw = n;
                        fs = F_SIG_DATA;
                    end
                end
                F_SIG_DATA:
                    if (tick(sigw))
                        sig_done();
                default: st = 1'b1;
            endcase
        endfunction

        function void len_word(bit is_text, field_t dataf, field_t nextf);
            int unsigned n;
            n = words_of(wc);
            if (is_text)
            begin
                tlen = wc;
                sks = n;
            end
            if (n == 0)
                fs = nextf;
            else
            begin
                skc = n;
                fs = dataf;
            end
        endfunction

        function void text_word(logic [3:0] k, field_t nextf);
            if (skc == sks)
            begin
                cap = k;
                txt = (tlen < WORD_BYTES) ? tlen : WORD_BYTES;
                shv = tlen[15:0];
            end
            if (tick(skc))
                fs = nextf;
        endfunction

        function void walk_text(bit ii);
            case (fs)
                F_NAME_OFF: fs = F_SYM_OFF;
                F_SYM_OFF:  fs = F_BURI_OFF;
                F_BURI_OFF: fs = F_CURI_OFF;
                F_CURI_OFF: fs = ii ? F_PROXY : F_OPS_OFF;
                F_OPS_OFF:  if (ii) st = 1'b1; else fs = F_TSALT;
                F_TSALT:    if (ii) st = 1'b1; else fs = F_NAME_LEN;
                F_PROXY:
                    if (!ii)
                        st = 1'b1;
                    else
                    begin
                        cap = CAP_PROXY;
                        fs = F_LAZY;
                    end
                F_LAZY:
                    if (!ii)
                        st = 1'b1;
                    else
                    begin
                        cap = CAP_LAZY;
                        fs = F_NAME_LEN;
                    end
                F_NAME_LEN: len_word(1'b1, F_NAME, F_SYM_LEN);
                F_NAME:     text_word(CAP_NAME, F_SYM_LEN);
                F_SYM_LEN:  len_word(1'b1, F_SYM, F_BURI_LEN);
                F_SYM:      text_word(CAP_SYMBOL, F_BURI_LEN);
                F_BURI_LEN: len_word(1'b0, F_BURI, F_CURI_LEN);
                F_BURI:     if (tick(skc)) fs = F_CURI_LEN;
                F_CURI_LEN: len_word(1'b0, F_CURI, ii ? F_DONE : F_OPS_QTY);
                F_CURI:     if (tick(skc)) fs = ii ? F_DONE : F_OPS_QTY;
                F_OPS_QTY:
                    if (ii)
                        st = 1'b1;
                    else
                    begin
                        skc = wc;
                        fs = (wc == 0) ? F_DONE : F_OP_ADDR;
                    end
                F_OP_ADDR:
                    if (ii)
                        st = 1'b1;
                    else
                    begin
                        if (skc == 1)
                            cap = CAP_OPERATOR;
                        fs = F_OP_VAL;
                    end
                F_OP_VAL:
                    if (ii)
                        st = 1'b1;
                    else
                        fs = tick(skc) ? F_DONE : F_OP_ADDR;
                default: st = 1'b1;
            endcase
        endfunction

        function void walk_match();
            case (side)
                SIDE_NONE:
                    case (fs)
                        F_LEFT_OFF:  fs = F_LSIG_OFF;
                        F_LSIG_OFF:  fs = F_RIGHT_OFF;
                        F_RIGHT_OFF: fs = F_RSIG_OFF;
                        F_RSIG_OFF:
                        begin
                            side = SIDE_LEFT;
                            fs = F_MAKER;
                        end
                        default: st = 1'b1;
                    endcase
                SIDE_LEFT:  walk_order(SIDE_RIGHT);
                SIDE_RIGHT: walk_order(SIDE_PAST);
                default:    st = 1'b1;
            endcase
        endfunction

        function void note_input(in_word_t w);
            out_word_t r;
            logic [1:0] side_in;
            if (w.first_word)
                restart();
            side_in = side;
            wc = w.word_3[COUNT_BITS-1:0];
            st = 1'b0; cap = CAP_NONE; txt = 0; shv = 16'd0;
            case (kind)
                KIND_MINT: walk_mint(1'b0);
                KIND_CANCEL:
                    if (fs == F_BODY_OFF)
                        fs = F_MAKER;
                    else
                        walk_order(SIDE_PAST);
                KIND_MATCH: walk_match();
                KIND_TRANSFER: walk_mint(1'b1);
                KIND_APPROVE:
                    case (fs)
                        F_TO:
                        begin
                            cap = CAP_TO;
                            fs = F_APPROVED;
                        end
                        F_APPROVED:
                        begin
                            cap = CAP_APPROVAL;
                            shv = w.word_3[15:0];
                            fs = F_DONE;
                        end
                        default: st = 1'b1;
                    endcase
                KIND_CREATE: walk_text(1'b0);
                KIND_INIT: walk_text(1'b1);
                default: st = 1'b1;
            endcase
            r.status = st;
            r.capture_kind = cap;
            r.side = side_in;
            r.text_bytes = txt[5:0];
            r.short_value = shv;
            expected_words.push_back(r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            if (expected_words.size() == 0)
            begin
                errs++;
                if (errs <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            e = expected_words.pop_front();
            if (got.status !== e.status || got.capture_kind !== e.capture_kind ||
                got.side !== e.side || got.text_bytes !== e.text_bytes ||
                got.short_value !== e.short_value)
            begin
                errs++;
                if (errs <= 10)
                    $display("mismatch: exp st=%0d cap=%0d side=%0d txt=%0d sh=%h,",
                             e.status, e.capture_kind, e.side, e.text_bytes,
                             e.short_value,
                             " got st=%0d cap=%0d side=%0d txt=%0d sh=%h",
                             got.status, got.capture_kind, got.side,
                             got.text_bytes, got.short_value);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_data;

    walk_scoreboard sb;

    abi_call_parameter_walker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_kind(logic [2:0] k);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 1'b0;
        pwdata <= {29'd0, k};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_kind(k);
    endtask

    task automatic send_word(in_word_t w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic in_word_t make_word(bit first, logic [15:0] low);
        in_word_t w;
        w.first_word = first;
        w.word_0 = {$urandom, $urandom};
        w.word_1 = {$urandom, $urandom};
        w.word_2 = {$urandom, $urandom};
        w.word_3 = {$urandom, $urandom};
        w.word_3[15:0] = low;
        return w;
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 16'd0;
        if (r < 10)
            return 16'($urandom_range(1, 70));
        if (r < 13)
        begin
            case ($urandom_range(0, 3))
                0: return 16'd1;
                1: return 16'd31;
                2: return 16'd32;
                default: return 16'd33;
            endcase
        end
        if (r == 19)
            return 16'($urandom);
        return 16'($urandom_range(1, 3));
    endfunction

    always
    begin
        int n;
        @(negedge clk);
        n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
        if (n > 0)
        begin
            out_ready <= 1'b0;
            repeat (n) @(negedge clk);
        end
        out_ready <= 1'b1;
        do
            @(posedge clk);
        while (!out_valid);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    initial
    begin
        in_word_t w;
        int       left;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = 32'd0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // mint with zero lengths and zero quantities, then past the layout
        write_kind(KIND_MINT);
        for (int i = 0; i < 14; i++)
        begin
            w = make_word(i == 0, 16'd0);
            if (i >= 12)
            begin
                w.word_0 = '1; w.word_1 = '1; w.word_2 = '1; w.word_3 = '1;
            end
            send_word(w);
        end
        drain();
        write_kind(KIND_APPROVE);
        send_word(make_word(1'b1, 16'd0));
        send_word(make_word(1'b0, 16'hFFFF));
        send_word(make_word(1'b0, 16'd5));
        drain();
        write_kind(KIND_UNSUP);
        send_word(make_word(1'b1, 16'd32));
        drain();

        for (int ph = 0; ph < 16; ph++)
        begin
            write_kind(ph[2:0]);
            left = 70;
            while (left > 0)
            begin
                int len;
                len = $urandom_range(3, 80);
                for (int i = 0; i < len && left > 0; i++)
                begin
                    send_word(make_word(i == 0 || $urandom_range(0, 99) == 0,
                                        pick_count()));
                    left--;
                end
            end
            drain();
        end

        if (sb.errs == 0 && sb.expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
